@@ hdl/lfmt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line formatter package
// Shared types and constants for the cat-style text line formatter.
// ----------------------------------------------------------------------------
package lfmt_pkg;

   // Register map, indexed by paddr[4:2].
   localparam logic [2:0] REG_SQUEEZE_BLANK    = 3'd0;
   localparam logic [2:0] REG_NUMBER_MODE      = 3'd1;
   localparam logic [2:0] REG_SHOW_NONPRINTING = 3'd2;
   localparam logic [2:0] REG_SHOW_TABS        = 3'd3;
   localparam logic [2:0] REG_SHOW_ENDS        = 3'd4;

   // Line numbering modes. The unused code acts as no numbering.
   localparam logic [1:0] NUM_NONE     = 2'd0;
   localparam logic [1:0] NUM_ALL      = 2'd1;
   localparam logic [1:0] NUM_NONBLANK = 2'd2;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_QMARK  = 8'h3F;
   localparam logic [7:0] CH_UPPER_I = 8'h49;
   localparam logic [7:0] CH_UPPER_M = 8'h4D;
   localparam logic [7:0] CH_CARET  = 8'h5E;
   localparam logic [7:0] CH_DEL    = 8'h7F;
   localparam logic [7:0] CTRL_OFFSET = 8'h40;
   localparam logic [7:0] HIGH_OFFSET = 8'h80;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic       squeeze_blank;
      logic [1:0] number_mode;
      logic       show_nonprinting;
      logic       show_tabs;
      logic       show_ends;
   } cfg_type;

   // One classified input byte: which pieces the back end has to emit.
   typedef struct packed {
      logic       num_en;
      logic       pre_m;
      logic       pre_caret;
      logic       pre_dollar;
      logic [7:0] ch;
   } cmd_type;

endpackage
`default_nettype wire

@@ hdl/lfmt_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line formatter front end
// Accepts raw bytes, tracks line state and the BCD line counter, and turns
// each byte that is not squeezed away into a command for the back end.
// ----------------------------------------------------------------------------
module lfmt_front #(
   parameter int NUMBER_DIGITS = 6
) (
   input  wire                           clock,
   input  wire                           reset,
   input  lfmt_pkg::cfg_type             cfg,
   input  wire                           in_accept,
   input  wire  [7:0]                    in_byte,
   output logic                          push,
   output lfmt_pkg::cmd_type             push_cmd,
   output logic [4*NUMBER_DIGITS-1:0]    push_digits
);

   localparam int DigitsW = 4 * NUMBER_DIGITS;

   logic                 at_line_start_ff, at_line_start_in;
   logic                 line_was_ended_ff, line_was_ended_in;
   logic [DigitsW-1:0]   line_bcd_ff, line_bcd_in;
   logic [1:0]           newline_run_ff, newline_run_in;

   logic                     is_lf;
   logic                     drop;
   logic                     bump;
   logic                     num_en;
   logic [NUMBER_DIGITS-1:0] is_nine;
   logic [NUMBER_DIGITS-1:0] carry;
   logic [DigitsW-1:0]       bcd_inc;
   logic [DigitsW-1:0]       bcd_next;
   lfmt_pkg::cmd_type        cmd;

   assign is_lf = (in_byte == lfmt_pkg::CH_LF);
   // A third newline in a row is swallowed whole and touches no state.
   assign drop  = cfg.squeeze_blank && is_lf && (newline_run_ff >= 2'd2);

   // Saturating BCD increment: a digit moves when all lower digits are nine.
   for (genvar gi = 0; gi < NUMBER_DIGITS; gi++) begin : g_digit
      assign is_nine[gi] = (line_bcd_ff[4*gi +: 4] == 4'd9);
      if (gi == 0) begin : g_lsd
         assign carry[gi] = 1'b1;
      end else begin : g_upper
         assign carry[gi] = carry[gi-1] & is_nine[gi-1];
      end
      assign bcd_inc[4*gi +: 4] = !carry[gi] ? line_bcd_ff[4*gi +: 4] :
                                  (is_nine[gi] ? 4'd0 : line_bcd_ff[4*gi +: 4] + 4'd1);
   end
   assign bcd_next = (&is_nine) ? line_bcd_ff : bcd_inc;

   always_comb begin
      at_line_start_in  = at_line_start_ff;
      line_was_ended_in = line_was_ended_ff;
      newline_run_in    = newline_run_ff;
      num_en            = 1'b0;
      bump              = 1'b0;

      if (cfg.squeeze_blank) begin
         if (!is_lf) begin
            newline_run_in = 2'd0;
         end else if (newline_run_ff < 2'd2) begin
            newline_run_in = newline_run_ff + 2'd1;
         end
      end

      case (cfg.number_mode)
         lfmt_pkg::NUM_ALL: begin
            num_en           = at_line_start_ff;
            at_line_start_in = is_lf;
            bump             = is_lf;
         end
         lfmt_pkg::NUM_NONBLANK: begin
            if (is_lf) begin
               at_line_start_in  = 1'b0;
               line_was_ended_in = 1'b1;
            end else begin
               at_line_start_in = 1'b1;
               num_en           = line_was_ended_ff;
               bump             = line_was_ended_ff;
               if (line_was_ended_ff) begin
                  line_was_ended_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase

      line_bcd_in = bump ? bcd_next : line_bcd_ff;
   end

   // Byte rendering: prefixes and the final character.
   always_comb begin
      cmd            = '0;
      cmd.num_en     = num_en;
      cmd.ch         = in_byte;
      if (cfg.show_nonprinting) begin
         if (in_byte <= 8'd8 || (in_byte >= 8'd11 && in_byte <= 8'd31)) begin
            cmd.pre_caret = 1'b1;
            cmd.ch        = in_byte + lfmt_pkg::CTRL_OFFSET;
         end else if (in_byte == lfmt_pkg::CH_DEL) begin
            cmd.pre_caret = 1'b1;
            cmd.ch        = lfmt_pkg::CH_QMARK;
         end else if (in_byte >= 8'd128 && in_byte <= 8'd159) begin
            cmd.pre_m     = 1'b1;
            cmd.pre_caret = 1'b1;
            cmd.ch        = in_byte - lfmt_pkg::CTRL_OFFSET;
         end else if (in_byte >= 8'd160 && in_byte <= 8'd254) begin
            cmd.pre_m = 1'b1;
            cmd.ch    = in_byte - lfmt_pkg::HIGH_OFFSET;
         end else if (in_byte == 8'd255) begin
            cmd.pre_m     = 1'b1;
            cmd.pre_caret = 1'b1;
            cmd.ch        = lfmt_pkg::CH_QMARK;
         end
      end
      if (in_byte == lfmt_pkg::CH_TAB && cfg.show_tabs) begin
         cmd.pre_caret = 1'b1;
         cmd.ch        = lfmt_pkg::CH_UPPER_I;
      end
      if (is_lf && cfg.show_ends) begin
         cmd.pre_dollar = 1'b1;
      end
   end

   assign push        = in_accept && !drop;
   assign push_cmd    = cmd;
   // The number printed is the one before this byte bumps it.
   assign push_digits = line_bcd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         at_line_start_ff  <= 1'b1;
         line_was_ended_ff <= 1'b1;
         line_bcd_ff       <= {{(DigitsW-1){1'b0}}, 1'b1};
         newline_run_ff    <= 2'd1;
      end else if (push) begin
         at_line_start_ff  <= at_line_start_in;
         line_was_ended_ff <= line_was_ended_in;
         line_bcd_ff       <= line_bcd_in;
         newline_run_ff    <= newline_run_in;
      end
   end

   dropped_keeps_state: assert property (@(posedge clock) disable iff (reset)
      (in_accept && drop) |=> $stable(line_bcd_ff) && $stable(newline_run_ff))
      else $error("dropped newline changed line state");

endmodule
`default_nettype wire

@@ hdl/lfmt_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line formatter command queue
// Short FIFO of classified bytes between the front and back ends.
// ----------------------------------------------------------------------------
module lfmt_queue #(
   parameter int DIGITS_W = 24
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  lfmt_pkg::cmd_type       push_cmd,
   input  wire  [DIGITS_W-1:0]     push_digits,
   input  wire                     pop,
   output logic                    full,
   output logic                    head_valid,
   output lfmt_pkg::cmd_type       head_cmd,
   output logic [DIGITS_W-1:0]     head_digits
);

   localparam int Depth = lfmt_pkg::QUEUE_DEPTH;
   localparam int PtrW  = $clog2(Depth);
   localparam int CntW  = $clog2(Depth + 1);

   lfmt_pkg::cmd_type   cmd_mem_ff [Depth];
   logic [DIGITS_W-1:0] dig_mem_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff;
   logic [PtrW-1:0]     rd_ptr_ff;
   logic [CntW-1:0]     count_ff;

   assign full        = (count_ff == CntW'(Depth));
   assign head_valid  = (count_ff != '0);
   assign head_cmd    = cmd_mem_ff[rd_ptr_ff];
   assign head_digits = dig_mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         cmd_mem_ff[wr_ptr_ff] <= push_cmd;
         dig_mem_ff[wr_ptr_ff] <= push_digits;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("queue overflow");

   no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue underflow");

   count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(Depth))
      else $error("queue count out of range");

endmodule
`default_nettype wire

@@ hdl/lfmt_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line formatter back end
// Walks each queued command and sends its output bytes one beat at a time:
// line number and tab, M- and caret prefixes, dollar, then the character.
// ----------------------------------------------------------------------------
module lfmt_back #(
   parameter int NUMBER_DIGITS = 6
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          head_valid,
   input  lfmt_pkg::cmd_type            head_cmd,
   input  wire  [4*NUMBER_DIGITS-1:0]   head_digits,
   output logic                         pop,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [7:0]                   rsp_tdata,
   output logic                         rsp_tlast
);

   localparam int IdxW = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
   localparam logic [IdxW-1:0] TopIdx = IdxW'(NUMBER_DIGITS - 1);

   typedef enum logic [2:0] {
      PH_START,
      PH_DIGIT,
      PH_TAB,
      PH_M,
      PH_DASH,
      PH_CARET,
      PH_DOLLAR,
      PH_CHAR
   } phase_type;

   phase_type       phase_ff, phase_in;
   logic [IdxW-1:0] digit_ff, digit_in;
   logic            lead_ff, lead_in;
   logic            rsp_valid_ff;
   logic [7:0]      rsp_byte_ff, rsp_byte_in;
   logic            rsp_last_ff, rsp_last_in;

   phase_type       cur_phase;
   phase_type       prefix_phase;
   logic [IdxW-1:0] cur_idx;
   logic            cur_lead;
   logic [3:0]      cur_digit;
   logic            load;

   assign load = head_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      if (head_cmd.pre_m) begin
         prefix_phase = PH_M;
      end else if (head_cmd.pre_caret) begin
         prefix_phase = PH_CARET;
      end else if (head_cmd.pre_dollar) begin
         prefix_phase = PH_DOLLAR;
      end else begin
         prefix_phase = PH_CHAR;
      end
   end

   always_comb begin
      if (phase_ff == PH_START) begin
         cur_phase = head_cmd.num_en ? PH_DIGIT : prefix_phase;
         cur_idx   = TopIdx;
         cur_lead  = 1'b1;
      end else begin
         cur_phase = phase_ff;
         cur_idx   = digit_ff;
         cur_lead  = lead_ff;
      end
      cur_digit = head_digits[4*cur_idx +: 4];

      phase_in    = cur_phase;
      digit_in    = cur_idx;
      lead_in     = cur_lead;
      rsp_last_in = 1'b0;
      rsp_byte_in = head_cmd.ch;

      case (cur_phase)
         PH_DIGIT: begin
            // Leading zeros print as spaces; the lowest digit always prints.
            if (cur_lead && cur_digit == 4'd0 && cur_idx != '0) begin
               rsp_byte_in = lfmt_pkg::CH_SPACE;
            end else begin
               rsp_byte_in = lfmt_pkg::CH_ZERO + {4'd0, cur_digit};
            end
            lead_in  = cur_lead && (cur_digit == 4'd0);
            digit_in = cur_idx - 1'b1;
            phase_in = (cur_idx == '0) ? PH_TAB : PH_DIGIT;
         end
         PH_TAB: begin
            rsp_byte_in = lfmt_pkg::CH_TAB;
            phase_in    = prefix_phase;
         end
         PH_M: begin
            rsp_byte_in = lfmt_pkg::CH_UPPER_M;
            phase_in    = PH_DASH;
         end
         PH_DASH: begin
            rsp_byte_in = lfmt_pkg::CH_DASH;
            phase_in    = head_cmd.pre_caret ? PH_CARET : PH_CHAR;
         end
         PH_CARET: begin
            rsp_byte_in = lfmt_pkg::CH_CARET;
            phase_in    = PH_CHAR;
         end
         PH_DOLLAR: begin
            rsp_byte_in = lfmt_pkg::CH_DOLLAR;
            phase_in    = PH_CHAR;
         end
         PH_CHAR: begin
            rsp_byte_in = head_cmd.ch;
            rsp_last_in = 1'b1;
            phase_in    = PH_START;
         end
         default: begin
            phase_in = PH_START;
         end
      endcase
   end

   assign pop = load && (cur_phase == PH_CHAR);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         digit_ff     <= '0;
         lead_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            phase_ff    <= phase_in;
            digit_ff    <= digit_in;
            lead_ff     <= lead_in;
            rsp_byte_ff <= rsp_byte_in;
            rsp_last_ff <= rsp_last_in;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;

   mid_run_has_entry: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_START) |-> head_valid)
      else $error("back end mid-run without a queued command");

   last_beat_ends_run: assert property (@(posedge clock) disable iff (reset)
      (load && rsp_last_in) |=> (phase_ff == PH_START) && rsp_tlast)
      else $error("last beat did not close the run");

endmodule
`default_nettype wire

@@ hdl/text_stream_line_formatter_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Text stream line formatter core
// Cat-style output filter: blank-line squeezing, line numbering, caret and
// M- notation, tab and line-end marking, with an APB register port.
// ----------------------------------------------------------------------------
// Accepted bytes pass through the command queue into the registered output.
// Each input byte yields 0 to 11 output beats (NUMBER_DIGITS + 5 at most);
// the back end sends one beat per cycle while commands wait and rsp_tready
// allows, and the front takes a byte every cycle while the four-entry
// command queue has room. Reset clears the registers to zero, the line
// counter to one and empties the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module text_stream_line_formatter_core #(
   parameter int NUMBER_DIGITS = 6
) (
   input  wire         clock,
   input  wire         reset,
   // Input stream
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,    // [7:0] in_byte
   // Output stream
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [7:0]  rsp_tdata,    // [7:0] out_byte
   output logic        rsp_tlast,    // last_of_run
   // Register port
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [4:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int DigitsW = 4 * NUMBER_DIGITS;

   lfmt_pkg::cfg_type   cfg_ff;
   logic                csr_write;
   logic [2:0]          reg_idx;

   logic                in_accept;
   logic                push;
   lfmt_pkg::cmd_type   push_cmd;
   logic [DigitsW-1:0]  push_digits;
   logic                pop;
   logic                full;
   logic                head_valid;
   lfmt_pkg::cmd_type   head_cmd;
   logic [DigitsW-1:0]  head_digits;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         case (reg_idx)
            lfmt_pkg::REG_SQUEEZE_BLANK:    cfg_ff.squeeze_blank    <= csr_pwdata[0];
            lfmt_pkg::REG_NUMBER_MODE:      cfg_ff.number_mode      <= csr_pwdata[1:0];
            lfmt_pkg::REG_SHOW_NONPRINTING: cfg_ff.show_nonprinting <= csr_pwdata[0];
            lfmt_pkg::REG_SHOW_TABS:        cfg_ff.show_tabs        <= csr_pwdata[0];
            lfmt_pkg::REG_SHOW_ENDS:        cfg_ff.show_ends        <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         lfmt_pkg::REG_SQUEEZE_BLANK:    csr_prdata = {31'd0, cfg_ff.squeeze_blank};
         lfmt_pkg::REG_NUMBER_MODE:      csr_prdata = {30'd0, cfg_ff.number_mode};
         lfmt_pkg::REG_SHOW_NONPRINTING: csr_prdata = {31'd0, cfg_ff.show_nonprinting};
         lfmt_pkg::REG_SHOW_TABS:        csr_prdata = {31'd0, cfg_ff.show_tabs};
         lfmt_pkg::REG_SHOW_ENDS:        csr_prdata = {31'd0, cfg_ff.show_ends};
         default:                        csr_prdata = 32'd0;
      endcase
   end

   assign req_tready = !full;
   assign in_accept  = req_tvalid && req_tready;

   lfmt_front #(
      .NUMBER_DIGITS (NUMBER_DIGITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_accept   (in_accept),
      .in_byte     (req_tdata),
      .push        (push),
      .push_cmd    (push_cmd),
      .push_digits (push_digits)
   );

   lfmt_queue #(
      .DIGITS_W (DigitsW)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_cmd    (push_cmd),
      .push_digits (push_digits),
      .pop         (pop),
      .full        (full),
      .head_valid  (head_valid),
      .head_cmd    (head_cmd),
      .head_digits (head_digits)
   );

   lfmt_back #(
      .NUMBER_DIGITS (NUMBER_DIGITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_cmd    (head_cmd),
      .head_digits (head_digits),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule
`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line formatter testbench
// Sends text bytes through the cat-style formatter core under random
// backpressure and source gaps, and checks every output beat against a
// behavioral formatter kept in step with the register settings.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int DIGITS = 6;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 10;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DIR_ROWS = 25;
   localparam int PHASES = 6;
   localparam int PHASE_ITEMS = 13;
   localparam int COUNTER_BURST = 40;

   localparam logic [1:0] NUM_UNUSED = 2'd3;
   localparam logic [2:0] REG_SPARE_LO = 3'd5;
   localparam logic [2:0] REG_SPARE_HI = 3'd7;

   localparam lfmt_pkg::cfg_type CFG_PLAIN     = '0;
   localparam lfmt_pkg::cfg_type CFG_SHOW_ALL  =
      '{1'b0, lfmt_pkg::NUM_NONE, 1'b1, 1'b1, 1'b1};
   localparam lfmt_pkg::cfg_type CFG_SQZ_NUM   =
      '{1'b1, lfmt_pkg::NUM_ALL, 1'b0, 1'b0, 1'b0};
   localparam lfmt_pkg::cfg_type CFG_NONBLANK  =
      '{1'b0, lfmt_pkg::NUM_NONBLANK, 1'b0, 1'b0, 1'b1};
   localparam lfmt_pkg::cfg_type CFG_MODE_3    = '{1'b0, NUM_UNUSED, 1'b1, 1'b1, 1'b1};
   localparam lfmt_pkg::cfg_type CFG_ALL_HIGH  =
      '{1'b1, lfmt_pkg::NUM_NONBLANK, 1'b1, 1'b1, 1'b1};
   localparam lfmt_pkg::cfg_type CFG_NUM_ONLY  =
      '{1'b0, lfmt_pkg::NUM_ALL, 1'b0, 1'b0, 1'b0};

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } beat_type;

   // One directed step. Where typed_len is nonzero, typed holds the expected
   // output text with its first character in the highest used byte.
   typedef struct packed {
      logic              set_cfg;
      lfmt_pkg::cfg_type cfg;
      logic [7:0]        ch;
      logic [3:0]        typed_len;
      logic [87:0]       typed;
   } step_row_type;

   step_row_type dir_rows [0:DIR_ROWS-1] = '{
      '{1'b1, CFG_PLAIN,    8'h41, 4'd1, "A"},
      '{1'b0, CFG_PLAIN,    8'h00, 4'd0, 88'd0},
      '{1'b0, CFG_PLAIN,    8'hFF, 4'd0, 88'd0},
      '{1'b1, CFG_SHOW_ALL, 8'h00, 4'd2, "^@"},
      '{1'b0, CFG_SHOW_ALL, 8'h1F, 4'd2, "^_"},
      '{1'b0, CFG_SHOW_ALL, 8'h7F, 4'd2, "^?"},
      '{1'b0, CFG_SHOW_ALL, 8'h80, 4'd4, "M-^@"},
      '{1'b0, CFG_SHOW_ALL, 8'h9F, 4'd4, "M-^_"},
      '{1'b0, CFG_SHOW_ALL, 8'hA0, 4'd3, "M- "},
      '{1'b0, CFG_SHOW_ALL, 8'hFE, 4'd3, "M-~"},
      '{1'b0, CFG_SHOW_ALL, 8'hFF, 4'd4, "M-^?"},
      '{1'b0, CFG_SHOW_ALL, 8'h09, 4'd2, "^I"},
      '{1'b0, CFG_SHOW_ALL, 8'h0A, 4'd2, "$\n"},
      '{1'b0, CFG_SHOW_ALL, 8'h20, 4'd1, " "},
      '{1'b1, CFG_SQZ_NUM,  8'h78, 4'd8, "     1\tx"},
      '{1'b0, CFG_SQZ_NUM,  8'h0A, 4'd0, 88'd0},
      '{1'b0, CFG_SQZ_NUM,  8'h0A, 4'd0, 88'd0},
      '{1'b0, CFG_SQZ_NUM,  8'h0A, 4'd0, 88'd0},
      '{1'b0, CFG_SQZ_NUM,  8'h0A, 4'd0, 88'd0},
      '{1'b0, CFG_SQZ_NUM,  8'h79, 4'd0, 88'd0},
      '{1'b1, CFG_NONBLANK, 8'h0A, 4'd0, 88'd0},
      '{1'b0, CFG_NONBLANK, 8'h7A, 4'd0, 88'd0},
      '{1'b0, CFG_NONBLANK, 8'h0A, 4'd0, 88'd0},
      '{1'b0, CFG_NONBLANK, 8'h71, 4'd0, 88'd0},
      '{1'b1, CFG_MODE_3,   8'h0A, 4'd2, "$\n"}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   wire         req_tready;
   logic [7:0]  req_tdata = '0;    // [7:0] in_byte
   wire         rsp_tvalid;
   logic        rsp_tready = 1'b0;
   wire  [7:0]  rsp_tdata;         // [7:0] out_byte
   wire         rsp_tlast;         // last_of_run
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   wire  [31:0] csr_prdata;
   wire         csr_pready;

   text_stream_line_formatter_core #(.NUMBER_DIGITS(DIGITS)) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   // Formatter settings and line state as the block should hold them.
   lfmt_pkg::cfg_type     fmt_cfg = '0;
   logic                  line_start = 1'b1;
   logic                  line_closed = 1'b1;
   logic [4*DIGITS-1:0]   line_count_bcd = {{(4*DIGITS-1){1'b0}}, 1'b1};
   logic [1:0]            lf_run = 2'd1;

   logic [7:0]  run_bytes [0:10];
   int          run_len;
   beat_type    pending_beats [$];
   beat_type    want;
   int          fail_count = 0;
   logic        quiet_run = 1'b0;
   logic        hold_off_req = 1'b0;
   int          stall_cycles;

   task automatic emit_byte(input logic [7:0] b);
      run_bytes[run_len] = b;
      run_len++;
   endtask

   task automatic emit_line_number();
      int         i;
      logic       lead;
      logic [3:0] d;
      lead = 1'b1;
      for (i = DIGITS - 1; i >= 0; i--) begin
         d = line_count_bcd[4*i +: 4];
         if (d != 4'd0 || i == 0)
            lead = 1'b0;
         emit_byte(lead ? lfmt_pkg::CH_SPACE : lfmt_pkg::CH_ZERO + {4'd0, d});
      end
      emit_byte(lfmt_pkg::CH_TAB);
   endtask

   // BCD increment that sticks at all nines.
   task automatic bump_line_count();
      int   i;
      logic carry;
      carry = 1'b1;
      if (line_count_bcd != {DIGITS{4'h9}}) begin
         for (i = 0; i < DIGITS; i++) begin
            if (carry) begin
               if (line_count_bcd[4*i +: 4] == 4'd9) begin
                  line_count_bcd[4*i +: 4] = 4'd0;
               end else begin
                  line_count_bcd[4*i +: 4] = line_count_bcd[4*i +: 4] + 4'd1;
                  carry = 1'b0;
               end
            end
         end
      end
   endtask

   // Leaves the output text of one input byte in run_bytes / run_len.
   task automatic format_byte(input logic [7:0] raw);
      logic [7:0] ch;
      ch = raw;
      run_len = 0;
      if (fmt_cfg.squeeze_blank) begin
         if (ch == lfmt_pkg::CH_LF) begin
            if (lf_run < 2'd2)
               lf_run = lf_run + 2'd1;
            else
               return;
         end else begin
            lf_run = 2'd0;
         end
      end
      if (fmt_cfg.number_mode == lfmt_pkg::NUM_ALL) begin
         if (line_start) begin
            emit_line_number();
            line_start = 1'b0;
         end
         if (ch == lfmt_pkg::CH_LF) begin
            line_start = 1'b1;
            bump_line_count();
         end
      end else if (fmt_cfg.number_mode == lfmt_pkg::NUM_NONBLANK) begin
         line_start = (ch != lfmt_pkg::CH_LF);
         if (ch == lfmt_pkg::CH_LF)
            line_closed = 1'b1;
         if (line_start && line_closed) begin
            emit_line_number();
            line_closed = 1'b0;
            bump_line_count();
         end
      end
      if (fmt_cfg.show_nonprinting) begin
         if (ch <= 8'h08 || (ch >= 8'h0B && ch <= 8'h1F)) begin
            emit_byte(lfmt_pkg::CH_CARET);
            ch = ch + lfmt_pkg::CTRL_OFFSET;
         end else if (ch == lfmt_pkg::CH_DEL) begin
            emit_byte(lfmt_pkg::CH_CARET);
            ch = lfmt_pkg::CH_QMARK;
         end else if (ch >= 8'h80 && ch <= 8'h9F) begin
            emit_byte(lfmt_pkg::CH_UPPER_M);
            emit_byte(lfmt_pkg::CH_DASH);
            emit_byte(lfmt_pkg::CH_CARET);
            ch = ch - lfmt_pkg::CTRL_OFFSET;
         end else if (ch >= 8'hA0 && ch <= 8'hFE) begin
            emit_byte(lfmt_pkg::CH_UPPER_M);
            emit_byte(lfmt_pkg::CH_DASH);
            ch = ch - lfmt_pkg::HIGH_OFFSET;
         end else if (ch == 8'hFF) begin
            emit_byte(lfmt_pkg::CH_UPPER_M);
            emit_byte(lfmt_pkg::CH_DASH);
            emit_byte(lfmt_pkg::CH_CARET);
            ch = lfmt_pkg::CH_QMARK;
         end
      end
      if (ch == lfmt_pkg::CH_TAB && fmt_cfg.show_tabs) begin
         emit_byte(lfmt_pkg::CH_CARET);
         ch = lfmt_pkg::CH_UPPER_I;
      end
      if (ch == lfmt_pkg::CH_LF && fmt_cfg.show_ends)
         emit_byte(lfmt_pkg::CH_DOLLAR);
      emit_byte(ch);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet_run || r < 60)
         return 0;
      else if (r < 90)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 30);
   endfunction

   // Mostly printable text and line breaks, with some arbitrary bytes.
   function automatic logic [7:0] pick_text_byte();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15)
         return lfmt_pkg::CH_LF;
      else if (r < 20)
         return lfmt_pkg::CH_TAB;
      else if (r < 70)
         return 8'($urandom_range(32, 126));
      else
         return 8'($urandom_range(0, 255));
   endfunction

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (idx)
         lfmt_pkg::REG_SQUEEZE_BLANK:    fmt_cfg.squeeze_blank = value[0];
         lfmt_pkg::REG_NUMBER_MODE:      fmt_cfg.number_mode = value[1:0];
         lfmt_pkg::REG_SHOW_NONPRINTING: fmt_cfg.show_nonprinting = value[0];
         lfmt_pkg::REG_SHOW_TABS:        fmt_cfg.show_tabs = value[0];
         lfmt_pkg::REG_SHOW_ENDS:        fmt_cfg.show_ends = value[0];
         default: ;
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   // Upper bits carry noise so that masking on write gets exercised.
   task automatic apply_settings(input lfmt_pkg::cfg_type c);
      logic [31:0] v;
      v = $urandom;
      v[0] = c.squeeze_blank;
      csr_write(lfmt_pkg::REG_SQUEEZE_BLANK, v);
      v = $urandom;
      v[1:0] = c.number_mode;
      csr_write(lfmt_pkg::REG_NUMBER_MODE, v);
      v = $urandom;
      v[0] = c.show_nonprinting;
      csr_write(lfmt_pkg::REG_SHOW_NONPRINTING, v);
      v = $urandom;
      v[0] = c.show_tabs;
      csr_write(lfmt_pkg::REG_SHOW_TABS, v);
      v = $urandom;
      v[0] = c.show_ends;
      csr_write(lfmt_pkg::REG_SHOW_ENDS, v);
      csr_write(3'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)), $urandom);
   endtask

   task automatic send_byte(input logic [7:0] b, input logic [3:0] typed_len,
                            input logic [87:0] typed);
      int       gap;
      int       k;
      beat_type bt;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      format_byte(b);
      // A typed row replaces the computed text but keeps the state update.
      if (typed_len != 4'd0) begin
         run_len = typed_len;
         for (k = 0; k < run_len; k++)
            run_bytes[k] = typed[8*(run_len - 1 - k) +: 8];
      end
      for (k = 0; k < run_len; k++) begin
         bt.data = run_bytes[k];
         bt.last = (k == run_len - 1);
         pending_beats.push_back(bt);
      end
   endtask

   // A squeezed newline leaves nothing to wait for, so a settling wait follows
   // the last beat before the registers are touched.
   task automatic await_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_beats.size() == 0) begin
            $error("unexpected output beat: out_byte %h last_of_run %b", rsp_tdata,
                   rsp_tlast);
            fail_count++;
         end else begin
            want = pending_beats.pop_front();
            if (rsp_tdata !== want.data) begin
               $error("out_byte: expected %h, actual %h", want.data, rsp_tdata);
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_of_run: expected %b, actual %b", want.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   // Output side: random stalls, plus one long hold-off on request.
   initial begin : receiver
      int r;
      forever begin
         @(negedge clock);
         r = $urandom_range(0, 99);
         if (hold_off_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
            hold_off_req = 1'b0;
         end else if (quiet_run || r < 60) begin
            rsp_tready <= 1'b1;
         end else if (r < 92) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(9, 39)) @(negedge clock);
         end
      end
   end

   initial begin : watchdog
      stall_cycles = 0;
      while (stall_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin : stimulus
      int                i;
      int                ph;
      int                k;
      lfmt_pkg::cfg_type c;
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIR_ROWS; i++) begin
         if (dir_rows[i].set_cfg) begin
            await_results();
            apply_settings(dir_rows[i].cfg);
         end
         send_byte(dir_rows[i].ch, dir_rows[i].typed_len, dir_rows[i].typed);
      end

      for (ph = 0; ph < PHASES; ph++) begin
         await_results();
         case (ph)
            0: c = CFG_ALL_HIGH;
            3: c = CFG_NUM_ONLY;
            4: c = CFG_PLAIN;
            default: c = lfmt_pkg::cfg_type'(6'($urandom_range(0, 63)));
         endcase
         apply_settings(c);
         quiet_run = (ph == 3);
         hold_off_req = (ph == 1);
         if (ph == 3) begin
            // Enough numbered lines to carry the counter into two digits.
            repeat (COUNTER_BURST) send_byte(lfmt_pkg::CH_LF, 4'd0, 88'd0);
         end else begin
            for (k = 0; k < PHASE_ITEMS; k++) begin
               if (ph == 2 && k == PHASE_ITEMS / 2)
                  await_results();
               if ($urandom_range(0, 9) == 0)
                  repeat ($urandom_range(2, 4)) send_byte(lfmt_pkg::CH_LF, 4'd0, 88'd0);
               send_byte(pick_text_byte(), 4'd0, 88'd0);
            end
         end
      end
      quiet_run = 1'b0;
      await_results();

      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
